// ===== rtl/bba_pkg.sv =====
package bba_pkg;

   // Defaults and fixed geometry of the bitmap
   localparam int MAP_WORDS_DEF = 8;
   localparam int WORD_BITS     = 32;

   localparam logic [4:0] SLOT_LOG2_MAX = 5'd16;

   // Request operations
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Response status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

   // Control register indexes
   localparam logic [1:0] CSR_POOL_BASE    = 2'd0;
   localparam logic [1:0] CSR_SLOT_LOG2    = 2'd1;
   localparam logic [1:0] CSR_WORDS_IN_USE = 2'd2;

   // Control register reset values
   localparam logic [31:0] POOL_BASE_RST    = 32'd0;
   localparam logic [4:0]  SLOT_LOG2_RST    = 5'd4;
   localparam logic [3:0]  WORDS_IN_USE_RST = 4'd8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUB,
      ST_LOCATE,
      ST_SET,
      ST_SCAN,
      ST_CLEAR,
      ST_RESP
   } state_type;

   typedef enum logic {
      SHIFT_LEFT,
      SHIFT_RIGHT
   } shift_dir_type;

   typedef struct packed {
      shift_dir_type dir;
      logic [31:0]   operand;
      logic [4:0]    amount;
   } unit_req_type;

   // Index of the lowest set bit; zero for an all-zero word
   function automatic logic [4:0] lowest_set(input logic [WORD_BITS-1:0] word);
      logic [4:0] pos;
      pos = 5'd0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (word[i]) begin
            pos = 5'(i);
         end
      end
      return pos;
   endfunction

endpackage

// ===== rtl/bba_channels.sv =====
interface bba_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [31:0] free_address;

   modport source (output valid, output operation, output free_address, input ready);
   modport sink   (input valid, input operation, input free_address, output ready);
endinterface

interface bba_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] slot_address;
   logic [1:0]  status;

   modport source (output valid, output slot_address, output status, input ready);
   modport sink   (input valid, input slot_address, input status, output ready);
endinterface

interface bba_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bitmap_block_allocator_core.sv =====
// Channel   Direction  Payload                        Transaction when
// req_chan  in         operation, free_address        valid & ready
// rsp_chan  out        slot_address, status           valid & ready
// csr_chan  in         index, data                    valid & ready (ready always high)
//
// One request at a time; req_chan.ready is high only when no request is in work.
// Free: subtract the base, then shift and read the word, then write it with the bit set;
// a free past the end of the pool skips the write, one below the base skips the shift and
// the write, and an empty pool answers at once. Allocate: one word read per cycle,
// checked by the priority encoder; a full pool stops after the last word in use.
// Reset is synchronous, active high; the response holds until rsp_chan.ready is seen.
module bitmap_block_allocator_core #(
   parameter int MAP_WORDS = bba_pkg::MAP_WORDS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bba_req_if.sink    req_chan,
   bba_rsp_if.source  rsp_chan,
   bba_csr_if.sink    csr_chan
);

   localparam int IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int CW    = (IDX_W > 4) ? IDX_W : 4;

   bba_pkg::state_type state_ff, state_in;

   logic [31:0] base_ff, base_in;
   logic [4:0]  log2_ff, log2_in;
   logic [3:0]  words_ff, words_in;

   logic [31:0]      addr_ff, addr_in;
   logic [CW-1:0]    iss_ff, iss_in;
   logic [CW-1:0]    chk_ff, chk_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] widx_ff, widx_in;
   logic [4:0]       bit_ff, bit_in;
   logic [31:0]      word_ff, word_in;
   logic [31:0]      res_addr_ff, res_addr_in;
   logic [1:0]       res_status_ff, res_status_in;

   logic [3:0]  act_words;
   logic [3:0]  last_word;
   logic [4:0]  sh_amt;
   logic [32:0] sub_full;
   logic        req_fire;
   logic        in_range;
   logic        hit;
   logic        scan_end;

   logic             rd_en;
   logic [IDX_W-1:0] rd_idx;
   logic [31:0]      rd_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [31:0]      wr_data;

   bba_pkg::unit_req_type unit_req;
   logic [31:0]           unit_result;

   bba_map #(
      .MAP_WORDS (MAP_WORDS),
      .IDX_W     (IDX_W)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data)
   );

   bba_shift_unit u_shift (
      .req    (unit_req),
      .base   (base_ff),
      .result (unit_result)
   );

   assign act_words = (int'(words_ff) > MAP_WORDS) ? 4'(MAP_WORDS) : words_ff;
   assign last_word = act_words - 4'd1;
   assign sh_amt    = (log2_ff > bba_pkg::SLOT_LOG2_MAX) ? bba_pkg::SLOT_LOG2_MAX : log2_ff;
   assign sub_full  = {1'b0, addr_ff} - {1'b0, base_ff};
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign in_range  = unit_result[31:5] < 27'(act_words);
   assign hit       = chk_vld_ff && (rd_data != '0);
   assign scan_end  = chk_vld_ff && (chk_ff == CW'(last_word));

   // Control registers
   always_comb begin
      base_in  = base_ff;
      log2_in  = log2_ff;
      words_in = words_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            bba_pkg::CSR_POOL_BASE:    base_in  = csr_chan.data;
            bba_pkg::CSR_SLOT_LOG2:    log2_in  = csr_chan.data[4:0];
            bba_pkg::CSR_WORDS_IN_USE: words_in = csr_chan.data[3:0];
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bba_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (act_words == 4'd0) begin
                  state_in = bba_pkg::ST_RESP;
               end else if (req_chan.operation == bba_pkg::OP_FREE) begin
                  state_in = bba_pkg::ST_SUB;
               end else begin
                  state_in = bba_pkg::ST_SCAN;
               end
            end
         end
         bba_pkg::ST_SUB: begin
            state_in = sub_full[32] ? bba_pkg::ST_RESP : bba_pkg::ST_LOCATE;
         end
         bba_pkg::ST_LOCATE: begin
            state_in = in_range ? bba_pkg::ST_SET : bba_pkg::ST_RESP;
         end
         bba_pkg::ST_SET: begin
            state_in = bba_pkg::ST_RESP;
         end
         bba_pkg::ST_SCAN: begin
            if (hit) begin
               state_in = bba_pkg::ST_CLEAR;
            end else if (scan_end) begin
               state_in = bba_pkg::ST_RESP;
            end
         end
         bba_pkg::ST_CLEAR: begin
            state_in = bba_pkg::ST_RESP;
         end
         bba_pkg::ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = bba_pkg::ST_IDLE;
            end
         end
         default: state_in = bba_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath
   always_comb begin
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      csr_chan.ready = 1'b1;

      addr_in       = addr_ff;
      iss_in        = iss_ff;
      chk_in        = chk_ff;
      chk_vld_in    = chk_vld_ff;
      widx_in       = widx_ff;
      bit_in        = bit_ff;
      word_in       = word_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;

      rd_en   = 1'b0;
      rd_idx  = widx_ff;
      wr_en   = 1'b0;
      wr_idx  = widx_ff;
      wr_data = word_ff;

      unit_req.dir     = bba_pkg::SHIFT_RIGHT;
      unit_req.operand = addr_ff;
      unit_req.amount  = sh_amt;

      unique case (state_ff)
         bba_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_fire) begin
               addr_in     = req_chan.free_address;
               iss_in      = '0;
               chk_in      = '0;
               chk_vld_in  = 1'b0;
               res_addr_in = '0;
               if (act_words != 4'd0) begin
                  res_status_in = bba_pkg::STATUS_OK;
               end else if (req_chan.operation == bba_pkg::OP_FREE) begin
                  res_status_in = bba_pkg::STATUS_OUTSIDE;
               end else begin
                  res_status_in = bba_pkg::STATUS_FULL;
               end
            end
         end
         bba_pkg::ST_SUB: begin
            addr_in = sub_full[31:0];
            if (sub_full[32]) begin
               res_status_in = bba_pkg::STATUS_OUTSIDE;
            end
         end
         bba_pkg::ST_LOCATE: begin
            widx_in = unit_result[IDX_W+4:5];
            bit_in  = unit_result[4:0];
            if (in_range) begin
               rd_en  = 1'b1;
               rd_idx = unit_result[IDX_W+4:5];
            end else begin
               res_status_in = bba_pkg::STATUS_OUTSIDE;
            end
         end
         bba_pkg::ST_SET: begin
            wr_en   = 1'b1;
            wr_data = rd_data | (32'd1 << bit_ff);
         end
         bba_pkg::ST_SCAN: begin
            // Issue one word per cycle; check the word read in the cycle before
            rd_en      = 1'b1;
            rd_idx     = iss_ff[IDX_W-1:0];
            chk_in     = iss_ff;
            chk_vld_in = 1'b1;
            if (iss_ff < CW'(last_word)) begin
               iss_in = iss_ff + CW'(1);
            end
            if (hit) begin
               word_in = rd_data;
               bit_in  = bba_pkg::lowest_set(rd_data);
               widx_in = chk_ff[IDX_W-1:0];
            end else if (scan_end) begin
               res_status_in = bba_pkg::STATUS_FULL;
            end
         end
         bba_pkg::ST_CLEAR: begin
            wr_en            = 1'b1;
            wr_data          = word_ff & ~(32'd1 << bit_ff);
            unit_req.dir     = bba_pkg::SHIFT_LEFT;
            unit_req.operand = 32'({widx_ff, bit_ff});
            res_addr_in      = unit_result;
            res_status_in    = bba_pkg::STATUS_OK;
         end
         bba_pkg::ST_RESP: begin
            rsp_chan.valid = 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_chan.slot_address = res_addr_ff;
   assign rsp_chan.status       = res_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bba_pkg::ST_IDLE;
         base_ff    <= bba_pkg::POOL_BASE_RST;
         log2_ff    <= bba_pkg::SLOT_LOG2_RST;
         words_ff   <= bba_pkg::WORDS_IN_USE_RST;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         base_ff    <= base_in;
         log2_ff    <= log2_in;
         words_ff   <= words_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      iss_ff        <= iss_in;
      chk_ff        <= chk_in;
      widx_ff       <= widx_in;
      bit_ff        <= bit_in;
      word_ff       <= word_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
   end

endmodule

// ===== rtl/bba_map.sv =====
module bba_map #(
   parameter int MAP_WORDS = bba_pkg::MAP_WORDS_DEF,
   parameter int IDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [IDX_W-1:0]                rd_idx,
   output logic [bba_pkg::WORD_BITS-1:0]   rd_data,
   input  logic                            wr_en,
   input  logic [IDX_W-1:0]                wr_idx,
   input  logic [bba_pkg::WORD_BITS-1:0]   wr_data
);

   logic [bba_pkg::WORD_BITS-1:0] mem [MAP_WORDS];
   logic [MAP_WORDS-1:0]          vld_ff;
   logic [MAP_WORDS-1:0]          vld_in;
   logic [bba_pkg::WORD_BITS-1:0] rd_word_ff;
   logic                          rd_vld_ff;

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_idx];
      end
   end

   // A word never written since reset reads as all free
   assign rd_data = rd_vld_ff ? rd_word_ff : '1;

endmodule

// ===== rtl/bba_shift_unit.sv =====
module bba_shift_unit (
   input  bba_pkg::unit_req_type req,
   input  logic [31:0]           base,
   output logic [31:0]           result
);

   logic [31:0] shifted;

   always_comb begin
      if (req.dir == bba_pkg::SHIFT_LEFT) begin
         shifted = req.operand << req.amount;
         result  = base + shifted;
      end else begin
         shifted = req.operand >> req.amount;
         result  = shifted;
      end
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   localparam int MAP_WORDS     = bba_pkg::MAP_WORDS_DEF;
   localparam int HOLD_OFF_LEN  = 300;
   localparam int STALL_LIMIT   = 5000;
   localparam int TAIL_CYCLES   = 20;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 70;

   // Register index with no register behind it
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [31:0] slot_address;
      logic [1:0]  status;
   } slot_reply_type;

   typedef enum logic {
      ROW_REQUEST,
      ROW_CSR_WRITE
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   index;
      logic [31:0]  value;
      logic         op;
      logic         typed;
      logic [31:0]  exp_address;
      logic [1:0]   exp_status;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;

   bba_req_if req_chan ();
   bba_rsp_if rsp_chan ();
   bba_csr_if csr_chan ();

   bitmap_block_allocator_core #(
      .MAP_WORDS(MAP_WORDS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   always #5 clock = ~clock;

   // Mirror of the allocator state
   logic [31:0] slot_map [MAP_WORDS];
   logic [31:0] pool_base_q;
   logic [4:0]  slot_log2_q;
   logic [3:0]  words_in_use_q;

   slot_reply_type replies_due [$];
   int             fail_count  = 0;
   int             stall_count = 0;
   bit             hold_off_req = 1'b0;

   script_row_type script_rows [24] = '{
      '{ROW_REQUEST,   bba_pkg::CSR_POOL_BASE,    32'hFFFF_FFFF, bba_pkg::OP_ALLOC, 1'b1,
        32'h0,  bba_pkg::STATUS_OK},
      '{ROW_REQUEST,   bba_pkg::CSR_POOL_BASE,    32'h0000_0000, bba_pkg::OP_ALLOC, 1'b1,
        32'h10, bba_pkg::STATUS_OK},
      '{ROW_REQUEST,   bba_pkg::CSR_POOL_BASE,    32'h0000_0010, bba_pkg::OP_FREE,  1'b1,
        32'h0,  bba_pkg::STATUS_OK},
      // misaligned address of a slot that is already free
      '{ROW_REQUEST,   bba_pkg::CSR_POOL_BASE,    32'h0000_001F, bba_pkg::OP_FREE,  1'b1,
        32'h0,  bba_pkg::STATUS_OK},
      '{ROW_REQUEST,   bba_pkg::CSR_POOL_BASE,    32'h0000_1000, bba_pkg::OP_FREE,  1'b1,
        32'h0,  bba_pkg::STATUS_OUTSIDE},
      '{ROW_REQUEST,   bba_pkg::CSR_POOL_BASE,    32'hFFFF_FFFF, bba_pkg::OP_FREE,  1'b1,
        32'h0,  bba_pkg::STATUS_OUTSIDE},
      '{ROW_REQUEST,   bba_pkg::CSR_POOL_BASE,    32'h1234_5678, bba_pkg::OP_ALLOC, 1'b0,
        32'h0,  bba_pkg::STATUS_OK},
      // empty pool
      '{ROW_CSR_WRITE, bba_pkg::CSR_WORDS_IN_USE, 32'h0000_0000, bba_pkg::OP_ALLOC, 1'b0,
        32'h0,  bba_pkg::STATUS_OK},
      '{ROW_REQUEST,   bba_pkg::CSR_POOL_BASE,    32'h0000_0000, bba_pkg::OP_ALLOC, 1'b1,
        32'h0,  bba_pkg::STATUS_FULL},
      '{ROW_REQUEST,   bba_pkg::CSR_POOL_BASE,    32'h0000_0000, bba_pkg::OP_FREE,  1'b1,
        32'h0,  bba_pkg::STATUS_OUTSIDE},
      // high base, clamped exponent and word count
      '{ROW_CSR_WRITE, bba_pkg::CSR_POOL_BASE,    32'hFFFF_0000, bba_pkg::OP_ALLOC, 1'b0,
        32'h0,  bba_pkg::STATUS_OK},
      '{ROW_CSR_WRITE, bba_pkg::CSR_SLOT_LOG2,    32'h0000_001F, bba_pkg::OP_ALLOC, 1'b0,
        32'h0,  bba_pkg::STATUS_OK},
      '{ROW_CSR_WRITE, bba_pkg::CSR_WORDS_IN_USE, 32'h0000_000F, bba_pkg::OP_ALLOC, 1'b0,
        32'h0,  bba_pkg::STATUS_OK},
      '{ROW_REQUEST,   bba_pkg::CSR_POOL_BASE,    32'h0000_0000, bba_pkg::OP_ALLOC, 1'b0,
        32'h0,  bba_pkg::STATUS_OK},
      '{ROW_REQUEST,   bba_pkg::CSR_POOL_BASE,    32'h0000_0000, bba_pkg::OP_FREE,  1'b1,
        32'h0,  bba_pkg::STATUS_OUTSIDE},
      '{ROW_REQUEST,   bba_pkg::CSR_POOL_BASE,    32'h0001_0005, bba_pkg::OP_FREE,  1'b0,
        32'h0,  bba_pkg::STATUS_OK},
      '{ROW_REQUEST,   bba_pkg::CSR_POOL_BASE,    32'hFFFF_8000, bba_pkg::OP_FREE,  1'b0,
        32'h0,  bba_pkg::STATUS_OK},
      // one-byte slots, single word
      '{ROW_CSR_WRITE, bba_pkg::CSR_SLOT_LOG2,    32'h0000_0000, bba_pkg::OP_ALLOC, 1'b0,
        32'h0,  bba_pkg::STATUS_OK},
      '{ROW_CSR_WRITE, bba_pkg::CSR_WORDS_IN_USE, 32'h0000_0001, bba_pkg::OP_ALLOC, 1'b0,
        32'h0,  bba_pkg::STATUS_OK},
      '{ROW_REQUEST,   bba_pkg::CSR_POOL_BASE,    32'hFFFF_001F, bba_pkg::OP_FREE,  1'b0,
        32'h0,  bba_pkg::STATUS_OK},
      '{ROW_REQUEST,   bba_pkg::CSR_POOL_BASE,    32'hFFFF_0020, bba_pkg::OP_FREE,  1'b1,
        32'h0,  bba_pkg::STATUS_OUTSIDE},
      '{ROW_REQUEST,   bba_pkg::CSR_POOL_BASE,    32'hA5A5_5A5A, bba_pkg::OP_ALLOC, 1'b0,
        32'h0,  bba_pkg::STATUS_OK},
      '{ROW_CSR_WRITE, CSR_UNMAPPED,              32'hA5A5_A5A5, bba_pkg::OP_ALLOC, 1'b0,
        32'h0,  bba_pkg::STATUS_OK},
      '{ROW_REQUEST,   bba_pkg::CSR_POOL_BASE,    32'h5A5A_A5A5, bba_pkg::OP_ALLOC, 1'b0,
        32'h0,  bba_pkg::STATUS_OK}
   };

   function automatic int unsigned active_words();
      return (words_in_use_q > MAP_WORDS) ? MAP_WORDS : int'(words_in_use_q);
   endfunction

   function automatic int unsigned slot_shift();
      return (slot_log2_q > bba_pkg::SLOT_LOG2_MAX) ? int'(bba_pkg::SLOT_LOG2_MAX)
                                                    : int'(slot_log2_q);
   endfunction

   // Update the mirrored bitmap for one request and return its reply
   function automatic slot_reply_type apply_slot_request(input logic op,
                                                         input logic [31:0] addr);
      slot_reply_type reply;
      int unsigned    words;
      int unsigned    shift;
      int unsigned    slot;
      logic [31:0]    offset;
      bit             found;
      reply = '{32'd0, bba_pkg::STATUS_FULL};
      words = active_words();
      shift = slot_shift();
      found = 1'b0;
      if (op == bba_pkg::OP_ALLOC) begin
         for (int w = 0; w < int'(words) && !found; w++) begin
            for (int b = 0; b < bba_pkg::WORD_BITS && !found; b++) begin
               if (slot_map[w][b]) begin
                  slot_map[w][b] = 1'b0;
                  slot = w * bba_pkg::WORD_BITS + b;
                  reply.slot_address = pool_base_q + (32'(slot) << shift);
                  reply.status = bba_pkg::STATUS_OK;
                  found = 1'b1;
               end
            end
         end
      end else begin
         offset = addr - pool_base_q;
         slot = offset >> shift;
         if (addr < pool_base_q || slot >= words * bba_pkg::WORD_BITS) begin
            reply.status = bba_pkg::STATUS_OUTSIDE;
         end else begin
            slot_map[slot / bba_pkg::WORD_BITS][slot % bba_pkg::WORD_BITS] = 1'b1;
            reply.status = bba_pkg::STATUS_OK;
         end
      end
      return reply;
   endfunction

   task automatic idle_sender(input int cycles);
      req_chan.valid <= 1'b0;
      req_chan.free_address <= $urandom;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic offer_request(input logic op, input logic [31:0] addr, input bit typed,
                                input slot_reply_type typed_reply);
      slot_reply_type reply;
      req_chan.valid <= 1'b1;
      req_chan.operation <= op;
      req_chan.free_address <= addr;
      do @(posedge clock); while (!req_chan.ready);
      reply = apply_slot_request(op, addr);
      replies_due.push_back(typed ? typed_reply : reply);
   endtask

   // Hold the sender until every reply has come back
   task automatic wait_replies_done();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (replies_due.size() != 0);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data <= value;
      do @(posedge clock); while (!csr_chan.ready);
      case (index)
         bba_pkg::CSR_POOL_BASE:    pool_base_q = value;
         bba_pkg::CSR_SLOT_LOG2:    slot_log2_q = value[4:0];
         bba_pkg::CSR_WORDS_IN_USE: words_in_use_q = value[3:0];
         default: ;
      endcase
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Draw one request, weighted toward frees of slots that are in use
   task automatic pick_slot_request(input int alloc_pct, output logic op,
                                    output logic [31:0] addr);
      int unsigned nslots;
      int unsigned shift;
      int unsigned slot;
      int unsigned kind;
      logic [31:0] in_slot;
      int unsigned used [$];
      nslots = active_words() * bba_pkg::WORD_BITS;
      shift = slot_shift();
      in_slot = $urandom & ((32'd1 << shift) - 32'd1);
      op = bba_pkg::OP_FREE;
      addr = $urandom;
      if ($urandom_range(0, 99) < alloc_pct) begin
         op = bba_pkg::OP_ALLOC;
      end else if (nslots != 0) begin
         kind = $urandom_range(0, 99);
         for (int s = 0; s < int'(nslots); s++) begin
            if (!slot_map[s / bba_pkg::WORD_BITS][s % bba_pkg::WORD_BITS]) used.push_back(s);
         end
         if (kind < 60 && used.size() != 0) begin
            slot = used[$urandom_range(0, used.size() - 1)];
            addr = pool_base_q + (32'(slot) << shift) + in_slot;
         end else if (kind < 75) begin
            slot = $urandom_range(0, nslots - 1);
            addr = pool_base_q + (32'(slot) << shift) + in_slot;
         end else if (kind < 85) begin
            addr = pool_base_q + (32'(nslots) << shift) + in_slot;
         end else if (kind < 93 && pool_base_q != 0) begin
            addr = pool_base_q - 32'd1 - (32'($urandom_range(0, 255)) % pool_base_q);
         end
      end
   endtask

   // Receiver: random stall patterns, plus one long hold-off on request
   initial begin : reply_sink
      int unsigned mode;
      int unsigned tick;
      tick = 0;
      forever begin
         if (hold_off_req) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_LEN) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(16, 96)) begin
               tick++;
               case (mode)
                  0: rsp_chan.ready <= 1'b1;
                  1: rsp_chan.ready <= $urandom_range(0, 1);
                  2: rsp_chan.ready <= (tick % 4 == 0);
                  default: rsp_chan.ready <= ($urandom_range(0, 7) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin : check_replies
      slot_reply_type due;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (replies_due.size() == 0) begin
            $error("unexpected reply: slot_address 0x%08h status %0d",
                   rsp_chan.slot_address, rsp_chan.status);
            fail_count++;
         end else begin
            due = replies_due.pop_front();
            if (rsp_chan.slot_address !== due.slot_address) begin
               $error("slot_address: expected 0x%08h, got 0x%08h",
                      due.slot_address, rsp_chan.slot_address);
               fail_count++;
            end
            if (rsp_chan.status !== due.status) begin
               $error("status: expected %0d, got %0d", due.status, rsp_chan.status);
               fail_count++;
            end
         end
      end
   end

   // Drop the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
      end
      if (stall_count >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      logic        op;
      logic [31:0] addr;
      logic [31:0] base_v;
      logic [4:0]  log2_v;
      logic [3:0]  words_v;
      int          burst_left;
      int          alloc_pct;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.operation <= bba_pkg::OP_ALLOC;
      req_chan.free_address <= 32'd0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= bba_pkg::CSR_POOL_BASE;
      csr_chan.data <= 32'd0;
      for (int w = 0; w < MAP_WORDS; w++) slot_map[w] = '1;
      pool_base_q = bba_pkg::POOL_BASE_RST;
      slot_log2_q = bba_pkg::SLOT_LOG2_RST;
      words_in_use_q = bba_pkg::WORDS_IN_USE_RST;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script_rows[i]) begin
         if (script_rows[i].kind == ROW_CSR_WRITE) begin
            wait_replies_done();
            write_csr(script_rows[i].index, script_rows[i].value);
         end else begin
            offer_request(script_rows[i].op, script_rows[i].value, script_rows[i].typed,
                          '{script_rows[i].exp_address, script_rows[i].exp_status});
            if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 3));
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_replies_done();
         if (phase == 0) begin
            base_v = 32'hFFFF_FFFF;
            log2_v = bba_pkg::SLOT_LOG2_MAX;
            words_v = 4'd8;
         end else if (phase == 1) begin
            base_v = 32'd0;
            log2_v = 5'd0;
            words_v = 4'd1;
         end else begin
            case ($urandom_range(0, 3))
               0: base_v = 32'd0;
               1: base_v = $urandom;
               2: base_v = $urandom & 32'hFFFF_F000;
               default: base_v = 32'hFFFF_FFFF - $urandom_range(0, 32'h000F_FFFF);
            endcase
            case ($urandom_range(0, 3))
               0: log2_v = 5'd0;
               1: log2_v = bba_pkg::SLOT_LOG2_MAX;
               2: log2_v = $urandom_range(17, 31);
               default: log2_v = $urandom_range(1, 15);
            endcase
            case ($urandom_range(0, 5))
               0, 1: words_v = 4'd1;
               2: words_v = 4'd2;
               3: words_v = $urandom_range(0, 15);
               4: words_v = 4'd8;
               default: words_v = $urandom_range(9, 15);
            endcase
         end
         write_csr(bba_pkg::CSR_POOL_BASE, base_v);
         write_csr(bba_pkg::CSR_SLOT_LOG2, ($urandom & ~32'h1F) | 32'(log2_v));
         write_csr(bba_pkg::CSR_WORDS_IN_USE, ($urandom & ~32'hF) | 32'(words_v));
         alloc_pct = (active_words() <= 2) ? 65 : 50;
         // stall the receiver for a long stretch while requests keep coming
         if (phase == 3) hold_off_req = 1'b1;
         burst_left = $urandom_range(1, 24);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick_slot_request(alloc_pct, op, addr);
            offer_request(op, addr, 1'b0, '{32'd0, bba_pkg::STATUS_OK});
            if (phase == 6 && n == PHASE_ITEMS / 2) wait_replies_done();
            burst_left--;
            if (burst_left == 0) begin
               if (phase % 4 != 2) idle_sender($urandom_range(1, 12));
               burst_left = $urandom_range(1, 24);
            end
         end
      end

      wait_replies_done();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && replies_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== bitmap_block_allocator_core.f =====
rtl/bba_pkg.sv
rtl/bba_channels.sv
rtl/bba_map.sv
rtl/bba_shift_unit.sv
rtl/bitmap_block_allocator_core.sv
sim/tb_top.sv
